/* design/mrs_pkg.sv */
package mrs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [31:0] TIME_STEP_RST  = 32'd42950;
  localparam logic [31:0] GAMMA_Q16      = 32'd1753337236;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [33:0] CORDIC_GAIN    = 34'h026DD3B6A;
  localparam logic [33:0] ONE_Q30        = 34'h040000000;

  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_ACQ_START = 2'd1;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL0, F_MUL1, F_MUL2, F_MUL3, F_PUSH
  } fstate_e;

  typedef enum logic [3:0] {
    B_IDLE, B_SQR, B_CHK, B_ROOT, B_ANGLE, B_CORDIC, B_FIN, B_DSET, B_DIV, B_ROT, B_OUT
  } bstate_e;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic               new_spin;
    logic signed [31:0] imx;
    logic signed [31:0] imy;
    logic signed [31:0] imz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               emit;
    logic [15:0]        idx;
  } mrs_item_t;

  function automatic logic [31:0] atan_q30(logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/mrs_front.sv */
module mrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               new_spin_i,
  input  logic signed [31:0] init_mx_i,
  input  logic signed [31:0] init_my_i,
  input  logic signed [31:0] init_mz_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] off_resonance_i,
  input  logic signed [31:0] rf_x_i,
  input  logic signed [31:0] rf_y_i,
  input  logic signed [31:0] grad_x_i,
  input  logic signed [31:0] grad_y_i,
  input  logic [15:0]        acq_start_i,
  input  logic               full_i,
  output logic               push_o,
  output mrs_pkg::mrs_item_t item_o
);
  import mrs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  fstate_e                  state_q, state_d;
  logic [COUNT_WIDTH-1:0]   cnt_q, cnt_d, cnt_base;
  mrs_item_t                item_q;
  logic signed [31:0]       posx_q, posy_q, gx_q, gy_q, off_q, g_q;
  logic signed [40:0]       acc_q;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       prod;
  logic signed [41:0]       zsum;
  logic [31:0]              diff;
  logic                     accept;

  assign accept   = in_valid_i && in_ready_o;
  assign prod     = mul_a * mul_b;
  assign cnt_base = new_spin_i ? '0 : cnt_q;
  assign diff     = 32'(cnt_base) - 32'(acq_start_i);
  assign cnt_d    = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
  assign zsum     = 42'(acc_q) + 42'($signed(prod[63:24])) + 42'(off_q);
  assign item_o   = item_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_MUL0;
      F_MUL0:  state_d = F_MUL1;
      F_MUL1:  state_d = F_MUL2;
      F_MUL2:  state_d = F_MUL3;
      F_MUL3:  state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    mul_a      = posx_q;
    mul_b      = gx_q;
    case (state_q)
      F_IDLE: in_ready_o = 1'b1;
      F_MUL0: begin
        mul_a = posx_q;
        mul_b = gx_q;
      end
      F_MUL1, F_MUL3: begin
        mul_a = g_q;
        mul_b = GAMMA_Q16;
      end
      F_MUL2: begin
        mul_a = posy_q;
        mul_b = gy_q;
      end
      F_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.new_spin <= new_spin_i;
      item_q.imx      <= init_mx_i;
      item_q.imy      <= init_my_i;
      item_q.imz      <= init_mz_i;
      item_q.wx       <= rf_x_i;
      item_q.wy       <= rf_y_i;
      item_q.emit     <= (32'(cnt_base) >= 32'(acq_start_i));
      item_q.idx      <= diff[15:0];
      posx_q          <= pos_x_i;
      posy_q          <= pos_y_i;
      gx_q            <= grad_x_i;
      gy_q            <= grad_y_i;
      off_q           <= off_resonance_i;
    end
    case (state_q)
      F_MUL0, F_MUL2: g_q <= prod[63:32];
      F_MUL1: acc_q <= 41'($signed(prod[63:24]));
      F_MUL3: item_q.wz <= sat32(72'(zsum));
      default: ;
    endcase
  end

endmodule

/* design/mrs_fifo.sv */
module mrs_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mrs_pkg::mrs_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output mrs_pkg::mrs_item_t item_o
);
  import mrs_pkg::*;

  mrs_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= item_i;
  end

endmodule

/* design/mrs_back.sv */
module mrs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  mrs_pkg::mrs_item_t item_i,
  output logic               pop_o,
  input  logic [31:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_mx_o,
  output logic signed [31:0] out_my_o,
  output logic signed [31:0] out_mz_o,
  output logic [15:0]        sample_index_o
);
  import mrs_pkg::*;

  bstate_e            state_q, state_d;
  logic [4:0]         k_q;
  logic [1:0]         lane_q;
  logic signed [31:0] mx_q, my_q, mz_q, wx_q, wy_q, wz_q;
  logic               emit_q;
  logic [15:0]        idx_q;
  logic [63:0]        sum_q, p_q;
  logic [35:0]        rem_q, rem2, trial;
  logic [31:0]        root_q;
  logic [127:0]       pp_q;
  logic [1:0]         quad_q;
  logic signed [33:0] x_q, y_q, z_q, sx, sy, atn, xc, yc;
  logic signed [31:0] cs_q, sn_q, ux_q, uy_q, uz_q;
  logic signed [32:0] omc_q;
  logic signed [33:0] cx_q, cy_q, cz_q, dot_q;
  logic signed [34:0] t_q;
  logic signed [71:0] acc_q, accp, accm, prs;
  logic [31:0]        drem_q, aw, ang;
  logic               dbit_q, dneg_q;
  logic [32:0]        dt;
  logic [30:0]        q_q;
  logic signed [31:0] wl;
  logic signed [34:0] ma, mb;
  logic signed [69:0] prod;
  logic               last_k, out_load;

  assign prod  = ma * mb;
  assign prs   = 72'(prod);
  assign accp  = acc_q + prs;
  assign accm  = acc_q - prs;
  assign rem2  = {rem_q[33:0], sum_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ang   = 32'(0) - pp_q[103:72];
  assign sx    = x_q >>> k_q;
  assign sy    = y_q >>> k_q;
  assign atn   = 34'(atan_q30(k_q));
  assign xc    = (x_q > $signed(ONE_Q30)) ? $signed(ONE_Q30) :
                 (x_q < -$signed(ONE_Q30)) ? -$signed(ONE_Q30) : x_q;
  assign yc    = (y_q > $signed(ONE_Q30)) ? $signed(ONE_Q30) :
                 (y_q < -$signed(ONE_Q30)) ? -$signed(ONE_Q30) : y_q;
  assign dt    = {drem_q, (k_q == 5'd0) ? dbit_q : 1'b0};

  always_comb begin
    case (lane_q)
      2'd0:    wl = wx_q;
      2'd1:    wl = wy_q;
      default: wl = wz_q;
    endcase
    aw = wl[31] ? 32'(-33'(wl)) : wl;
  end

  always_comb begin
    case (state_q)
      B_SQR:    last_k = (k_q == 5'd2);
      B_ROOT:   last_k = (k_q == 5'd31);
      B_ANGLE:  last_k = (k_q == 5'd5);
      B_CORDIC: last_k = (k_q == 5'd30);
      B_DIV:    last_k = (k_q == 5'd30);
      B_ROT:    last_k = (k_q == 5'd18);
      default:  last_k = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (!empty_i) state_d = B_SQR;
      B_SQR:    if (last_k) state_d = B_CHK;
      B_CHK:    state_d = (sum_q == '0) ? B_OUT : B_ROOT;
      B_ROOT:   if (last_k) state_d = B_ANGLE;
      B_ANGLE:  if (last_k) state_d = B_CORDIC;
      B_CORDIC: if (last_k) state_d = B_FIN;
      B_FIN:    state_d = B_DSET;
      B_DSET:   state_d = B_DIV;
      B_DIV:    if (last_k) state_d = (lane_q == 2'd2) ? B_ROT : B_DSET;
      B_ROT:    if (last_k) state_d = B_OUT;
      B_OUT:    if (!emit_q || !out_valid_o || out_ready_i) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    out_load = (state_q == B_OUT) && emit_q && (!out_valid_o || out_ready_i);
    ma       = '0;
    mb       = '0;
    case (state_q)
      B_SQR: begin
        case (k_q)
          5'd0:    ma = 35'(wx_q);
          5'd1:    ma = 35'(wy_q);
          default: ma = 35'(wz_q);
        endcase
        mb = ma;
      end
      B_ANGLE: begin
        case (k_q)
          5'd0: begin
            ma = {3'b000, root_q};
            mb = {3'b000, time_step_i};
          end
          5'd1: begin
            ma = {3'b000, p_q[31:0]};
            mb = {3'b000, INV_TWO_PI_Q64[31:0]};
          end
          5'd2: begin
            ma = {3'b000, p_q[31:0]};
            mb = {3'b000, INV_TWO_PI_Q64[63:32]};
          end
          5'd3: begin
            ma = {3'b000, p_q[63:32]};
            mb = {3'b000, INV_TWO_PI_Q64[31:0]};
          end
          5'd4: begin
            ma = {3'b000, p_q[63:32]};
            mb = {3'b000, INV_TWO_PI_Q64[63:32]};
          end
          default: begin
            ma = {5'b00000, ang[29:0]};
            mb = {4'b0000, HALF_PI_Q30};
          end
        endcase
      end
      B_ROT: begin
        case (k_q)
          5'd0:  begin ma = 35'(uy_q); mb = 35'(mz_q); end
          5'd1:  begin ma = 35'(uz_q); mb = 35'(my_q); end
          5'd2:  begin ma = 35'(uz_q); mb = 35'(mx_q); end
          5'd3:  begin ma = 35'(ux_q); mb = 35'(mz_q); end
          5'd4:  begin ma = 35'(ux_q); mb = 35'(my_q); end
          5'd5:  begin ma = 35'(uy_q); mb = 35'(mx_q); end
          5'd6:  begin ma = 35'(ux_q); mb = 35'(mx_q); end
          5'd7:  begin ma = 35'(uy_q); mb = 35'(my_q); end
          5'd8:  begin ma = 35'(uz_q); mb = 35'(mz_q); end
          5'd9:  begin ma = 35'(omc_q); mb = 35'(dot_q); end
          5'd10: begin ma = 35'(cs_q); mb = 35'(mx_q); end
          5'd11: begin ma = 35'(sn_q); mb = 35'(cx_q); end
          5'd12: begin ma = t_q; mb = 35'(ux_q); end
          5'd13: begin ma = 35'(cs_q); mb = 35'(my_q); end
          5'd14: begin ma = 35'(sn_q); mb = 35'(cy_q); end
          5'd15: begin ma = t_q; mb = 35'(uy_q); end
          5'd16: begin ma = 35'(cs_q); mb = 35'(mz_q); end
          5'd17: begin ma = 35'(sn_q); mb = 35'(cz_q); end
          default: begin ma = t_q; mb = 35'(uz_q); end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      lane_q      <= '0;
      out_valid_o <= 1'b0;
      mx_q        <= '0;
      my_q        <= '0;
      mz_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) k_q <= '0;
      else k_q <= k_q + 1'b1;
      if (state_q == B_FIN) lane_q <= '0;
      else if (state_q == B_DIV && last_k) lane_q <= lane_q + 1'b1;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (pop_o && item_i.new_spin) begin
        mx_q <= item_i.imx;
        my_q <= item_i.imy;
        mz_q <= item_i.imz;
      end
      // The new vector lands one component at a time; cross products are done by then.
      if (state_q == B_ROT) begin
        case (k_q)
          5'd12: mx_q <= sat32(acc_q + (prs >>> 30));
          5'd15: my_q <= sat32(acc_q + (prs >>> 30));
          5'd18: mz_q <= sat32(acc_q + (prs >>> 30));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wx_q   <= item_i.wx;
      wy_q   <= item_i.wy;
      wz_q   <= item_i.wz;
      emit_q <= item_i.emit;
      idx_q  <= item_i.idx;
      sum_q  <= '0;
    end
    case (state_q)
      B_SQR: sum_q <= sum_q + prod[63:0];
      B_CHK: begin
        rem_q  <= '0;
        root_q <= '0;
      end
      B_ROOT: begin
        sum_q <= {sum_q[61:0], 2'b00};
        if (rem2 >= trial) begin
          rem_q  <= rem2 - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem2;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      B_ANGLE: begin
        case (k_q)
          5'd0: p_q <= prod[63:0];
          5'd1: pp_q <= 128'(prod[63:0]);
          5'd2, 5'd3: pp_q <= pp_q + (128'(prod[63:0]) << 32);
          5'd4: pp_q <= pp_q + (128'(prod[63:0]) << 64);
          default: begin
            z_q    <= 34'(prod[60:30]);
            quad_q <= ang[31:30];
            x_q    <= $signed(CORDIC_GAIN);
            y_q    <= '0;
          end
        endcase
      end
      B_CORDIC: begin
        if (z_q >= 0) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - atn;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + atn;
        end
      end
      B_FIN: begin
        case (quad_q)
          2'd0: begin
            cs_q  <= 32'(xc);
            sn_q  <= 32'(yc);
            omc_q <= 33'($signed(ONE_Q30) - xc);
          end
          2'd1: begin
            cs_q  <= 32'(-yc);
            sn_q  <= 32'(xc);
            omc_q <= 33'($signed(ONE_Q30) + yc);
          end
          2'd2: begin
            cs_q  <= 32'(-xc);
            sn_q  <= 32'(-yc);
            omc_q <= 33'($signed(ONE_Q30) + xc);
          end
          default: begin
            cs_q  <= 32'(yc);
            sn_q  <= 32'(-xc);
            omc_q <= 33'($signed(ONE_Q30) - yc);
          end
        endcase
      end
      B_DSET: begin
        // |w| * 2^30 shifted down by 31 is the starting partial remainder.
        drem_q <= {1'b0, aw[31:1]};
        dbit_q <= aw[0];
        dneg_q <= wl[31];
        q_q    <= '0;
      end
      B_DIV: begin
        if (dt >= {1'b0, root_q}) begin
          drem_q <= 32'(dt - {1'b0, root_q});
          q_q    <= {q_q[29:0], 1'b1};
        end else begin
          drem_q <= dt[31:0];
          q_q    <= {q_q[29:0], 1'b0};
        end
        if (last_k) begin
          case (lane_q)
            2'd0:    ux_q <= dneg_q ? -$signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}})
                                    : $signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}});
            2'd1:    uy_q <= dneg_q ? -$signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}})
                                    : $signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}});
            default: uz_q <= dneg_q ? -$signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}})
                                    : $signed({1'b0, q_q[29:0], dt >= {1'b0, root_q}});
          endcase
        end
      end
      B_ROT: begin
        case (k_q)
          5'd0, 5'd2, 5'd4, 5'd6: acc_q <= prs;
          5'd1: cx_q <= 34'(accm >>> 30);
          5'd3: cy_q <= 34'(accm >>> 30);
          5'd5: cz_q <= 34'(accm >>> 30);
          5'd7: acc_q <= accp;
          5'd8: begin
            if ((accp >>> 30) > 72'sd4294967295) dot_q <= 34'sd4294967295;
            else if ((accp >>> 30) < -72'sd4294967295) dot_q <= -34'sd4294967295;
            else dot_q <= 34'(accp >>> 30);
          end
          5'd9: t_q <= 35'(prs >>> 30);
          5'd10, 5'd13, 5'd16: acc_q <= prs >>> 30;
          5'd11, 5'd14, 5'd17: acc_q <= acc_q + (prs >>> 30);
          default: ;
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      out_mx_o       <= mx_q;
      out_my_o       <= my_q;
      out_mz_o       <= mz_q;
      sample_index_o <= idx_q;
    end
  end

endmodule

/* design/magnetization_rotation_step.sv */
// Rotates one spin's magnetization about the effective field for each time sample
// (Rodrigues rotation by -|W|*time_step, no relaxation) and returns the rotated vector
// from sample acquire_start on. The front end registers a sample and its time index on
// acceptance, then forms the gradient field; a two-beat queue hands it to the rotation
// engine, which works on one sample at a time: a 32-step square root, six multiplier
// steps for the angle, a 31-step CORDIC, three shift-subtract divisions for the unit axis
// and 19 steps of the shared multiplier for the rotation itself. That engine sets the
// throughput. A sample with a zero field skips the rotation. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module magnetization_rotation_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               new_spin_i,
  input  logic signed [31:0] init_mx_i,
  input  logic signed [31:0] init_my_i,
  input  logic signed [31:0] init_mz_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] off_resonance_i,
  input  logic signed [31:0] rf_x_i,
  input  logic signed [31:0] rf_y_i,
  input  logic signed [31:0] grad_x_i,
  input  logic signed [31:0] grad_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_mx_o,
  output logic signed [31:0] out_my_o,
  output logic signed [31:0] out_mz_o,
  output logic [15:0]        sample_index_o
);
  import mrs_pkg::*;

  logic [31:0] time_step_q;
  logic [15:0] acq_start_q;
  logic        push, full, pop, empty;
  mrs_item_t   f_item, b_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      acq_start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP: time_step_q <= cfg_wdata_i;
        CFG_ACQ_START: acq_start_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  mrs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .new_spin_i,
    .init_mx_i, .init_my_i, .init_mz_i, .pos_x_i, .pos_y_i, .off_resonance_i,
    .rf_x_i, .rf_y_i, .grad_x_i, .grad_y_i,
    .acq_start_i(acq_start_q), .full_i(full), .push_o(push), .item_o(f_item)
  );

  mrs_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(b_item)
  );

  mrs_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(b_item), .pop_o(pop),
    .time_step_i(time_step_q), .out_valid_o, .out_ready_i,
    .out_mx_o, .out_my_o, .out_mz_o, .sample_index_o
  );

endmodule

/* verif/magnetization_rotation_step_tb.sv */
module magnetization_rotation_step_tb;
  import mrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1500;
  localparam int HOLD_CYCLES    = 3000;

  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] UNIT = 32'sh40000000;

  localparam longint GAMMA_L   = 64'd1753337236;
  localparam longint ONE_L     = 64'd1073741824;
  localparam longint GAIN_L    = 64'h26DD3B6A;
  localparam longint DOT_LIM   = 64'd4294967295;
  localparam logic [63:0] HALF_PI_U  = 64'd1686629713;
  localparam logic [63:0] INV_2PI_U  = 64'h28BE60DB9391054A;

  localparam longint ARCTAN [31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001
  };

  typedef struct {
    logic               new_spin;
    logic signed [31:0] imx;
    logic signed [31:0] imy;
    logic signed [31:0] imz;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] off;
    logic signed [31:0] rf_x;
    logic signed [31:0] rf_y;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
  } sample_t;

  typedef struct {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic [15:0]        idx;
  } spin_result_t;

  typedef struct {
    sample_t      s;
    bit           typed;
    spin_result_t r;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_TIME_STEP;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic new_spin_i = 1'b0;
  logic signed [31:0] init_mx_i = '0, init_my_i = '0, init_mz_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, off_resonance_i = '0;
  logic signed [31:0] rf_x_i = '0, rf_y_i = '0, grad_x_i = '0, grad_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_mx_o, out_my_o, out_mz_o;
  logic [15:0] sample_index_o;

  // Model copy of the spin state and the registers.
  logic signed [31:0] spin_x, spin_y, spin_z;
  logic [15:0]        sample_cnt;
  logic [31:0]        step_reg;
  logic [15:0]        acq_reg;

  spin_result_t rotated_q[$];
  int  fail_cnt = 0;
  int  idle_cnt = 0;
  bit  hold_req = 1'b0;

  magnetization_rotation_step uut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate_sample(input sample_t s, output bit emit,
                                        output spin_result_t r);
    longint w[3], u[3], m[3], c[3];
    longint g0, g1, cs, sn, dot, omc, t, z, x, y, nx, magl;
    logic [63:0] sum, rem, res, bitv, zz, p;
    logic [127:0] wide;
    logic [31:0] ang;
    logic [15:0] tt;
    int i;
    if (s.new_spin) begin
      spin_x = s.imx;
      spin_y = s.imy;
      spin_z = s.imz;
      sample_cnt = '0;
    end
    w[0] = s.rf_x;
    w[1] = s.rf_y;
    g0 = ((longint'(s.pos_x) * longint'(s.grad_x)) >>> 32) * GAMMA_L >>> 24;
    g1 = ((longint'(s.pos_y) * longint'(s.grad_y)) >>> 32) * GAMMA_L >>> 24;
    w[2] = clampl(g0 + g1 + longint'(s.off), -64'sd2147483648, 64'sd2147483647);
    sum = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
    if (sum != 0) begin
      // Integer square root, two bits of the radicand per step.
      rem = sum;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      p = res * {32'd0, step_reg};
      wide = {64'd0, p} * {64'd0, INV_2PI_U};
      ang = 32'd0 - wide[103:72];
      zz = {34'd0, ang[29:0]} * HALF_PI_U;
      z = longint'(zz >> 30);
      x = GAIN_L;
      y = 0;
      for (i = 0; i < 31; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - ARCTAN[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + ARCTAN[i];
        end
        x = nx;
      end
      x = clampl(x, -ONE_L, ONE_L);
      y = clampl(y, -ONE_L, ONE_L);
      case (ang[31:30])
        2'd0: begin cs = x;  sn = y;  end
        2'd1: begin cs = -y; sn = x;  end
        2'd2: begin cs = -x; sn = -y; end
        default: begin cs = y; sn = -x; end
      endcase
      magl = longint'(res);
      m[0] = spin_x;
      m[1] = spin_y;
      m[2] = spin_z;
      for (i = 0; i < 3; i++) u[i] = (w[i] * ONE_L) / magl;
      c[0] = (u[1] * m[2] - u[2] * m[1]) >>> 30;
      c[1] = (u[2] * m[0] - u[0] * m[2]) >>> 30;
      c[2] = (u[0] * m[1] - u[1] * m[0]) >>> 30;
      dot = clampl((u[0] * m[0] + u[1] * m[1] + u[2] * m[2]) >>> 30, -DOT_LIM, DOT_LIM);
      omc = ONE_L - cs;
      t = (omc * dot) >>> 30;
      for (i = 0; i < 3; i++)
        m[i] = clampl(((cs * m[i]) >>> 30) + ((sn * c[i]) >>> 30) + ((t * u[i]) >>> 30),
                      -64'sd2147483648, 64'sd2147483647);
      spin_x = m[0][31:0];
      spin_y = m[1][31:0];
      spin_z = m[2][31:0];
    end
    tt = sample_cnt;
    if (sample_cnt != 16'hFFFF) sample_cnt = sample_cnt + 16'd1;
    emit = (tt >= acq_reg);
    r.mx = spin_x;
    r.my = spin_y;
    r.mz = spin_z;
    r.idx = tt - acq_reg;
  endfunction

  // One sample beat: random gap, offer, wait for acceptance, then predict.
  task automatic send_sample(sample_t s, bit typed, spin_result_t typed_r);
    int gap;
    bit emit;
    spin_result_t r;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    new_spin_i      <= s.new_spin;
    init_mx_i       <= s.imx;
    init_my_i       <= s.imy;
    init_mz_i       <= s.imz;
    pos_x_i         <= s.pos_x;
    pos_y_i         <= s.pos_y;
    off_resonance_i <= s.off;
    rf_x_i          <= s.rf_x;
    rf_y_i          <= s.rf_y;
    grad_x_i        <= s.grad_x;
    grad_y_i        <= s.grad_y;
    do @(posedge clk_i); while (!in_ready_o);
    rotate_sample(s, emit, r);
    if (emit) rotated_q.push_back(typed ? typed_r : r);
  endtask

  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] ts, logic [15:0] acq);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TIME_STEP;
    cfg_wdata_i <= ts;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ACQ_START;
    cfg_wdata_i <= {16'd0, acq};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_reg = ts;
    acq_reg  = acq;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return $urandom;
      4, 5, 6: return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
      7: return MAXV;
      8: return MINV;
      default: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
    endcase
  endfunction

  function automatic sample_t rand_sample(bit zero_only);
    sample_t s;
    s.new_spin = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 1)) begin
      s.imx = $urandom; s.imy = $urandom; s.imz = $urandom;
    end else begin
      s.imx = rand_word() >>> 1; s.imy = rand_word() >>> 1; s.imz = UNIT;
    end
    s.pos_x = rand_word();
    s.pos_y = rand_word();
    if (zero_only || $urandom_range(0, 9) == 0) begin
      s.off = '0; s.rf_x = '0; s.rf_y = '0; s.grad_x = '0; s.grad_y = '0;
    end else begin
      s.off = rand_word(); s.rf_x = rand_word(); s.rf_y = rand_word();
      s.grad_x = rand_word(); s.grad_y = rand_word();
    end
    return s;
  endfunction

  task automatic run_random(int n, bit zero_only);
    spin_result_t none;
    none = '{default: '0};
    repeat (n) send_sample(rand_sample(zero_only), 1'b0, none);
  endtask

  dir_row_t directed [15] = '{
    // Nothing loaded since reset: the zero vector stays zero.
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, 0, 0, 0, MAXV, 0, 0, 0}, 1, '{0, 0, 0, 16'd1}},
    // Zero field keeps the loaded vector untouched.
    '{'{1, MAXV, MINV, 0, MAXV, MINV, 0, 0, 0, 0, 0}, 1, '{MAXV, MINV, 0, 16'd0}},
    '{'{0, 0, 0, 0, MINV, MAXV, 0, 0, 0, 0, 0}, 1, '{MAXV, MINV, 0, 16'd1}},
    '{'{1, UNIT, 0, 0, 0, 0, 0, MAXV, 0, 0, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, 0, 0, 0, MINV, MINV, 0, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{1, 0, UNIT, 0, 0, 0, 0, 0, MAXV, 0, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, 0, 0, MAXV, 0, 0, 0, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, 0, 0, MINV, 0, 0, 0, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{1, UNIT, UNIT, UNIT, MAXV, 0, 0, 0, 0, MAXV, 0}, 0, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, MINV, MINV, 0, 0, 0, MINV, MAXV}, 0, '{0, 0, 0, 16'd0}},
    '{'{0, 0, 0, 0, 0, MAXV, MAXV, 1, 0, 0, MINV}, 0, '{0, 0, 0, 16'd0}},
    '{'{1, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 0,
      '{0, 0, 0, 16'd0}},
    '{'{1, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}, 0,
      '{0, 0, 0, 16'd0}},
    '{'{1, 0, 0, UNIT, 0, 0, 256, -256, 1, 0, 0}, 0, '{0, 0, 0, 16'd0}}
  };

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int stall;
    spin_result_t e;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (rotated_q.size() == 0) begin
        $error("unexpected result beat: mx %0d my %0d mz %0d index %0d",
               out_mx_o, out_my_o, out_mz_o, sample_index_o);
        fail_cnt++;
      end else begin
        e = rotated_q.pop_front();
        if (out_mx_o !== e.mx) begin
          $error("out_mx: expected %0d, got %0d", e.mx, out_mx_o);
          fail_cnt++;
        end
        if (out_my_o !== e.my) begin
          $error("out_my: expected %0d, got %0d", e.my, out_my_o);
          fail_cnt++;
        end
        if (out_mz_o !== e.mz) begin
          $error("out_mz: expected %0d, got %0d", e.mz, out_mz_o);
          fail_cnt++;
        end
        if (sample_index_o !== e.idx) begin
          $error("sample_index: expected %0d, got %0d", e.idx, sample_index_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    spin_x = '0;
    spin_y = '0;
    spin_z = '0;
    sample_cnt = '0;
    step_reg = TIME_STEP_RST;
    acq_reg = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_sample(directed[i].s, directed[i].typed, directed[i].r);
    run_random(200, 1'b0);
    settle();

    configure(32'hFFFFFFFF, 16'd0);
    hold_req = 1'b1;
    run_random(250, 1'b0);
    settle();

    configure(32'd0, 16'd3);
    run_random(200, 1'b0);
    settle();

    configure($urandom, 16'($urandom_range(0, 20)));
    run_random(250, 1'b0);
    settle();

    configure($urandom_range(1000, 200000), 16'd0);
    run_random(250, 1'b0);
    settle();

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
